### hdl/slid_pkg.sv
// Shared types and codes for the sorted list insert/delete block.
`timescale 1ns / 1ps

package slid_pkg;

  // Operation requested with each beat on the command side.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // Status reported with each result beat.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Broadcast control from the list controller to every cell.
  typedef struct packed {
    logic ins;  // insert accepted: cells at or after the slot shift up
    logic del;  // delete with a match: cells from the match shift down
  } cell_ctl_t;

endpackage

### hdl/slid_cell.sv
// One storage cell of the sorted list chain.
`timescale 1ns / 1ps

module slid_cell import slid_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic                   occupied,
  input  logic                   prev_after,
  input  logic [VALUE_WIDTH-1:0] prev_value,
  input  logic [VALUE_WIDTH-1:0] next_value,
  output logic [VALUE_WIDTH-1:0] stored,
  output logic                   after,
  output logic                   match
);

  logic ge;
  logic at_or_past;

  // Local comparisons against the broadcast key.
  assign ge         = $signed(stored) >= $signed(key);
  assign after      = !occupied || ge;
  assign at_or_past = occupied && ge;
  assign match      = occupied && (stored == key);

  // An insert moves everything after the slot up one place and drops the key
  // into the slot; a delete pulls the tail down over the first match.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (prev_after) begin
        stored <= prev_value;
      end else if (after) begin
        stored <= key;
      end
    end else if (ctl.del) begin
      if (at_or_past) begin
        stored <= next_value;
      end
    end
  end

endmodule

### hdl/sorted_list_insert_delete.sv
// Top level of the sorted list insert/delete block.
`timescale 1ns / 1ps

// Holds up to DEPTH signed values in ascending order in a chain of cells.
// A command beat is taken whenever start is high; busy is always low, so a
// new command may follow in every cycle. Each command gives exactly one
// result beat, marked by done, in the cycle after the command is taken; the
// receiver cannot hold it off, so it must take it in that cycle. All cells
// compare the value against their own entry in parallel and shift one place
// in the same clock, which sets the rate of one command per cycle. An insert
// into a full list reports full, and a delete with no equal entry reports
// not found; in both cases the list is left as it was.
module sorted_list_insert_delete import slid_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           action,
  input  logic [VALUE_WIDTH-1:0]         value,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [$clog2(DEPTH+1)-1:0]     entry_count,
  output logic [VALUE_WIDTH-1:0]         smallest_value,
  output logic                           smallest_valid
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  status_t                result_status;
  status_t                result_status_next;
  cell_ctl_t              ctl;
  logic                   accept;
  logic                   full;
  logic                   found;

  logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]       cell_occupied;
  logic [DEPTH-1:0]       cell_after;
  logic [DEPTH-1:0]       cell_match;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));
  assign found  = |cell_match;

  // Broadcast control to the chain.
  assign ctl.ins = accept && (action == ACT_INSERT) && !full;
  assign ctl.del = accept && (action == ACT_DELETE) && found;

  // The chain of cells; each sees its neighbours' entries and flags.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   prev_after;
    logic [VALUE_WIDTH-1:0] prev_value;
    logic [VALUE_WIDTH-1:0] next_value;

    assign cell_occupied[i] = (count > CW'(i));

    if (i == 0) begin : g_first
      assign prev_after = 1'b0;
      assign prev_value = value;
    end else begin : g_mid
      assign prev_after = cell_after[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_value = cell_value[i];
    end else begin : g_inner
      assign next_value = cell_value[i+1];
    end

    slid_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (value),
      .occupied   (cell_occupied[i]),
      .prev_after (prev_after),
      .prev_value (prev_value),
      .next_value (next_value),
      .stored     (cell_value[i]),
      .after      (cell_after[i]),
      .match      (cell_match[i])
    );
  end

  // Entry count and status for the result beat.
  always_comb begin
    count_next         = count;
    result_status_next = ST_DONE;
    if (action == ACT_INSERT) begin
      if (full) begin
        result_status_next = ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      if (found) begin
        count_next = count - CW'(1);
      end else begin
        result_status_next = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      done          <= 1'b0;
      result_status <= ST_DONE;
    end else begin
      done <= accept;
      if (accept) begin
        count         <= count_next;
        result_status <= result_status_next;
      end
    end
  end

  // Result beat fields follow the list state after the command.
  assign status         = result_status;
  assign entry_count    = count;
  assign smallest_valid = (count != '0);
  assign smallest_value = smallest_valid ? cell_value[0] : '0;

  // Checks on the controller.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("command without a result beat");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && (result_status == ST_FULL) |-> full)
    else $error("full reported while space remains");

  a_not_found_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && (action == ACT_DELETE) && !found |=> count == $past(count))
    else $error("failed delete changed the count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not add one entry");

  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(ctl.ins && ctl.del))
    else $error("insert and delete shift together");

endmodule
